// ----- rtl/serial_frame_deframer_unit_assert.svh -----
// Assertion macros shared by the deframer RTL.
// SFD_ASSERT_IMP: the consequent must hold in the same cycle as the antecedent.
// SFD_ASSERT_NXT: the consequent must hold one cycle after the antecedent.
`ifndef SERIAL_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define SERIAL_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SFD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("deframer assertion failed");
`define SFD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("deframer assertion failed");
`else
`define SFD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SFD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/sfd_pkg.sv -----
package sfd_pkg;

    // Default payload buffer size
    localparam int MAX_PAYLOAD_DEF = 256;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_VALUE = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  SYNC_FIRST_RST  = 8'd109;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'd98;
    localparam logic [15:0] CHECK_VALUE_RST = 16'hCACB;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_GOOD     = 2'd1;
    localparam logic [1:0] KIND_MISMATCH = 2'd2;
    localparam logic [1:0] KIND_ABORT    = 2'd3;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [15:0] check_value;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] command;
        logic [15:0] length;
        logic [7:0]  byte_index;
    } t_result;

endpackage

// ----- rtl/sfd_cfg_regs.sv -----
module sfd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output sfd_pkg::t_cfg                 o_cfg
);
    import sfd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write and update the addressed register
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SYNC_FIRST:  n_cfg.sync_first  = i_cfg_data[7:0];
                CFG_SYNC_SECOND: n_cfg.sync_second = i_cfg_data[7:0];
                CFG_CHECK_VALUE: n_cfg.check_value = i_cfg_data[15:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= SYNC_FIRST_RST;
            r_cfg.sync_second <= SYNC_SECOND_RST;
            r_cfg.check_value <= CHECK_VALUE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/sfd_parser.sv -----
`include "serial_frame_deframer_unit_assert.svh"

module sfd_parser #(
    parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sfd_pkg::t_cfg   i_cfg,
    input  logic            i_fire,
    input  logic [7:0]      i_byte,
    input  logic            i_out_stall,
    output logic            o_free,
    output logic            o_out_valid,
    output sfd_pkg::t_result o_result
);
    import sfd_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD - 1);
    localparam int LIMIT = MAX_PAYLOAD - 2;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CMD0    = 4'd2,
        PH_CMD1    = 4'd3,
        PH_LEN0    = 4'd4,
        PH_LEN1    = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CHK0    = 4'd7,
        PH_CHK1    = 4'd8
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [15:0]       r_cmd, n_cmd;
    logic [15:0]       r_len, n_len;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [7:0]        r_chk_low, n_chk_low;
    logic              r_out_valid, n_out_valid;
    t_result           r_result, n_result;

    logic              w_has_res;
    logic              w_room;
    logic [CNT_W-1:0]  w_cnt_inc;
    logic [15:0]       w_chk;

    // Result register can take a new item when empty or being drained
    assign o_free    = !r_out_valid || !i_out_stall;
    assign w_room    = (16'(r_cnt) < r_len) && (r_cnt < CNT_W'(LIMIT));
    assign w_cnt_inc = r_cnt + 1'b1;
    assign w_chk     = {i_byte, r_chk_low};

    // Step the parser by one byte
    always_comb begin
        n_phase   = r_phase;
        n_cmd     = r_cmd;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_chk_low = r_chk_low;
        w_has_res = 1'b0;
        n_result  = '{kind: KIND_PAYLOAD, data_byte: 8'd0, command: r_cmd,
                      length: r_len, byte_index: 8'd0};
        unique case (r_phase)
            PH_SYNC2: n_phase = (i_byte == i_cfg.sync_second) ? PH_CMD0 : PH_HUNT;
            PH_CMD0: begin
                n_cmd   = {8'd0, i_byte};
                n_phase = PH_CMD1;
            end
            PH_CMD1: begin
                n_cmd   = {i_byte, r_cmd[7:0]};
                n_phase = PH_LEN0;
            end
            PH_LEN0: begin
                n_len   = {8'd0, i_byte};
                n_phase = PH_LEN1;
            end
            PH_LEN1: begin
                n_len   = {i_byte, r_len[7:0]};
                n_phase = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                w_has_res = 1'b1;
                if (w_room) begin
                    n_cnt               = w_cnt_inc;
                    n_result.data_byte  = i_byte;
                    n_result.byte_index = 8'(r_cnt);
                    if (16'(w_cnt_inc) == r_len) begin
                        n_phase = PH_CHK0;
                    end
                end else begin
                    // Overrun: drop the frame
                    n_result.kind = KIND_ABORT;
                    n_phase       = PH_HUNT;
                end
            end
            PH_CHK0: begin
                n_chk_low = i_byte;
                n_phase   = PH_CHK1;
            end
            PH_CHK1: begin
                w_has_res     = 1'b1;
                n_result.kind = (w_chk == i_cfg.check_value) ? KIND_GOOD : KIND_MISMATCH;
                n_phase       = PH_HUNT;
            end
            default: begin
                // Hunt for the first sync byte; unused codes land here too
                if (i_byte == i_cfg.sync_first) begin
                    n_cmd   = 16'd0;
                    n_len   = 16'd0;
                    n_cnt   = '0;
                    n_phase = PH_SYNC2;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        endcase
    end

    // Load or drain the result register
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_free) begin
            n_out_valid = i_fire && w_has_res;
        end
    end

    // Hold parser state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_cmd       <= 16'd0;
            r_len       <= 16'd0;
            r_cnt       <= '0;
            r_chk_low   <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_fire) begin
                r_phase   <= n_phase;
                r_cmd     <= n_cmd;
                r_len     <= n_len;
                r_cnt     <= n_cnt;
                r_chk_low <= n_chk_low;
            end
        end
        if (i_fire && o_free) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    `SFD_ASSERT_IMP(a_cnt_in_limit, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(LIMIT))
    `SFD_ASSERT_IMP(a_chk_after_full, i_clk, i_rst_n, r_phase == PH_CHK0, 16'(r_cnt) == r_len)
    `SFD_ASSERT_IMP(a_fire_needs_room, i_clk, i_rst_n, i_fire, o_free)

endmodule

// ----- rtl/serial_frame_deframer_unit.sv -----
// Channel  | valid      | stall       | payload
// ---------+------------+-------------+---------------------------------------------
// input    | i_in_valid | o_in_stall  | i_rx_byte
// result   | o_out_valid| i_out_stall | o_kind o_data_byte o_command o_length
//          |            |             | o_byte_index
// config   | i_cfg_we   | -           | i_cfg_index i_cfg_data
//
// One byte per cycle unless the result side stalls; each result is held in a result register.
// Path: input register -> parser step -> result register.
// A byte with no result (sync, header, hunting, first check byte) is still held by a stall.
// Reset is synchronous, active low; no clearing pass, the block is ready at once.
// While the result side stalls, one more byte is held in the input register.
`include "serial_frame_deframer_unit_assert.svh"

module serial_frame_deframer_unit #(
    parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_kind,
    output logic [7:0]                    o_data_byte,
    output logic [15:0]                   o_command,
    output logic [15:0]                   o_length,
    output logic [7:0]                    o_byte_index
);
    import sfd_pkg::*;

    t_cfg       w_cfg;
    t_result    w_result;
    logic       w_free;
    logic       w_fire;
    logic       w_in_acc;
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;

    sfd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Input register: advance when the parser can move on
    assign w_fire     = r_in_valid && w_free;
    assign o_in_stall = r_in_valid && !w_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_acc) begin
            n_in_valid = 1'b1;
        end else if (w_fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
        if (w_in_acc) begin
            r_in_byte <= i_rx_byte;
        end
    end

    sfd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_fire      (w_fire),
        .i_byte      (r_in_byte),
        .i_out_stall (i_out_stall),
        .o_free      (w_free),
        .o_out_valid (o_out_valid),
        .o_result    (w_result)
    );

    assign o_kind       = w_result.kind;
    assign o_data_byte  = w_result.data_byte;
    assign o_command    = w_result.command;
    assign o_length     = w_result.length;
    assign o_byte_index = w_result.byte_index;

    `SFD_ASSERT_NXT(a_held_item_kept, i_clk, i_rst_n, r_in_valid && !w_free, r_in_valid)
    `SFD_ASSERT_IMP(a_status_fields_clear, i_clk, i_rst_n,
        o_out_valid && (o_kind != KIND_PAYLOAD), (o_data_byte == 8'd0) && (o_byte_index == 8'd0))

endmodule

// ----- dv/sfd_frame_checker.sv -----
`timescale 1ns / 1ps

module sfd_frame_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [7:0]                     i_rx_byte,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [1:0]                     i_kind,
    input  logic [7:0]                     i_data_byte,
    input  logic [15:0]                    i_command,
    input  logic [15:0]                    i_length,
    input  logic [7:0]                     i_byte_index,
    output int                             o_fails,
    output int                             o_pending,
    output int                             o_n_data,
    output int                             o_n_good,
    output int                             o_n_bad,
    output int                             o_n_abort
);
    import sfd_pkg::*;

    // Payload bytes a frame may carry before it is cut short
    localparam int PAYLOAD_CAP = MAX_PAYLOAD_DEF - 2;

    typedef enum logic [3:0] {
        ST_HUNT,
        ST_SYNC2,
        ST_CMD_LO,
        ST_CMD_HI,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_PAYLOAD,
        ST_CHK_LO,
        ST_CHK_HI
    } t_parse_st;

    t_cfg      cfg;
    t_parse_st st;
    logic [15:0] cur_cmd;
    logic [15:0] cur_len;
    logic [15:0] rx_count;
    logic [7:0]  chk_lo;
    t_result     frame_results_q[$];

    // Advance the parser by one byte; return 1 when the byte yields a result
    function automatic bit parse_byte(input logic [7:0] rx, output t_result res);
        logic [15:0] chk;
        res = '0;
        res.command = cur_cmd;
        res.length  = cur_len;
        case (st)
            ST_SYNC2: begin
                // a wrong second sync byte is dropped, not retried as a first
                st = (rx == cfg.sync_second) ? ST_CMD_LO : ST_HUNT;
                return 1'b0;
            end
            ST_CMD_LO: begin
                cur_cmd = {8'h00, rx};
                st = ST_CMD_HI;
                return 1'b0;
            end
            ST_CMD_HI: begin
                cur_cmd[15:8] = rx;
                st = ST_LEN_LO;
                return 1'b0;
            end
            ST_LEN_LO: begin
                cur_len = {8'h00, rx};
                st = ST_LEN_HI;
                return 1'b0;
            end
            ST_LEN_HI: begin
                cur_len[15:8] = rx;
                st = ST_PAYLOAD;
                return 1'b0;
            end
            ST_PAYLOAD: begin
                if (rx_count < cur_len && rx_count < PAYLOAD_CAP) begin
                    res.kind       = KIND_PAYLOAD;
                    res.data_byte  = rx;
                    res.byte_index = rx_count[7:0];
                    rx_count++;
                    if (rx_count == cur_len) begin
                        st = ST_CHK_LO;
                    end
                    return 1'b1;
                end
                // overrun of the declared length or of the buffer
                res.kind = KIND_ABORT;
                st = ST_HUNT;
                return 1'b1;
            end
            ST_CHK_LO: begin
                chk_lo = rx;
                st = ST_CHK_HI;
                return 1'b0;
            end
            ST_CHK_HI: begin
                chk = {rx, chk_lo};
                res.kind = (chk == cfg.check_value) ? KIND_GOOD : KIND_MISMATCH;
                st = ST_HUNT;
                return 1'b1;
            end
            default: begin
                if (rx == cfg.sync_first) begin
                    cur_cmd  = '0;
                    cur_len  = '0;
                    rx_count = '0;
                    st = ST_SYNC2;
                end else begin
                    st = ST_HUNT;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // Compare results, track register writes, predict from accepted bytes
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result fresh;
        if (!i_rst_n) begin
            cfg      = '{SYNC_FIRST_RST, SYNC_SECOND_RST, CHECK_VALUE_RST};
            st       = ST_HUNT;
            cur_cmd  = '0;
            cur_len  = '0;
            rx_count = '0;
            chk_lo   = '0;
            frame_results_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_kind, i_data_byte, i_command, i_length, i_byte_index};
                if (frame_results_q.size() == 0) begin
                    o_fails <= o_fails + 1;
                    $display("%0t ns: result with none expected: kind=%0d data=%02h cmd=%04h len=%04h idx=%0d",
                             $time, got.kind, got.data_byte, got.command, got.length,
                             got.byte_index);
                end else begin
                    want = frame_results_q.pop_front();
                    if (got !== want) begin
                        o_fails <= o_fails + 1;
                        $display("%0t ns: expected kind=%0d data=%02h cmd=%04h len=%04h idx=%0d",
                                 $time, want.kind, want.data_byte, want.command, want.length,
                                 want.byte_index);
                        $display("%0t ns:   actual kind=%0d data=%02h cmd=%04h len=%04h idx=%0d",
                                 $time, got.kind, got.data_byte, got.command, got.length,
                                 got.byte_index);
                    end
                    case (want.kind)
                        KIND_PAYLOAD:  o_n_data  <= o_n_data + 1;
                        KIND_GOOD:     o_n_good  <= o_n_good + 1;
                        KIND_MISMATCH: o_n_bad   <= o_n_bad + 1;
                        default:       o_n_abort <= o_n_abort + 1;
                    endcase
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SYNC_FIRST:  cfg.sync_first  = i_cfg_data[7:0];
                    CFG_SYNC_SECOND: cfg.sync_second = i_cfg_data[7:0];
                    CFG_CHECK_VALUE: cfg.check_value = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                if (parse_byte(i_rx_byte, fresh)) begin
                    frame_results_q.push_back(fresh);
                end
            end
        end
        o_pending <= frame_results_q.size();
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import sfd_pkg::*;

    // index with no register behind it; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int RAND_PER_SETTING = 30;
    localparam int RUN_LIMIT_NS = 400_000;
    localparam int N_SETTINGS = 5;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic [7:0]            i_rx_byte = '0;
    logic                  i_out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [1:0]            o_kind;
    logic [7:0]            o_data_byte;
    logic [15:0]           o_command;
    logic [15:0]           o_length;
    logic [7:0]            o_byte_index;

    int fails;
    int pending;
    int n_data;
    int n_good;
    int n_bad;
    int n_abort;

    int gap_max = 4;
    int stall_max = 4;
    int n_sent = 0;

    // stimulus-side copy of the framing registers
    logic [7:0]  sync_a = SYNC_FIRST_RST;
    logic [7:0]  sync_b = SYNC_SECOND_RST;
    logic [15:0] check_word = CHECK_VALUE_RST;

    serial_frame_deframer_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_data_byte  (o_data_byte),
        .o_command    (o_command),
        .o_length     (o_length),
        .o_byte_index (o_byte_index)
    );

    sfd_frame_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_kind       (o_kind),
        .i_data_byte  (o_data_byte),
        .i_command    (o_command),
        .i_length     (o_length),
        .i_byte_index (o_byte_index),
        .o_fails      (fails),
        .o_pending    (pending),
        .o_n_data     (n_data),
        .o_n_good     (n_good),
        .o_n_bad      (n_bad),
        .o_n_abort    (n_abort)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop should the block hang
    initial begin
        #RUN_LIMIT_NS;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: hold stall for a random count, then take one item
    initial begin
        int n;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            n = $urandom_range(0, stall_max);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Offer one byte after a random gap and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
    endtask

    // Full frame; n_payload may differ from len to force truncation or overrun
    task automatic send_frame(input logic [15:0] cmd, input logic [15:0] len,
                              input int n_payload, input bit good_chk);
        logic [15:0] chk;
        chk = good_chk ? check_word : 16'($urandom);
        send_byte(sync_a);
        send_byte(sync_b);
        send_byte(cmd[7:0]);
        send_byte(cmd[15:8]);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        repeat (n_payload) send_byte(8'($urandom));
        send_byte(chk[7:0]);
        send_byte(chk[15:8]);
    endtask

    // Drop valid and wait until every expected result is out and the pipe is empty
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_SYNC_FIRST:  sync_a = val[7:0];
            CFG_SYNC_SECOND: sync_b = val[7:0];
            CFG_CHECK_VALUE: check_word = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly well-formed frames, with zero-length, broken sync, noise and bad lengths
    task automatic run_random(input int n_items);
        int stop;
        int pick;
        int len;
        logic [7:0] bad;
        stop = n_sent + n_items;
        while (n_sent < stop) begin
            if ($urandom_range(0, 15) == 0) begin
                gap_max   = 4 * $urandom_range(0, 1);
                stall_max = 4 * $urandom_range(0, 1);
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                len = $urandom_range(1, 6);
                send_frame(16'($urandom), 16'(len), len, $urandom_range(0, 3) != 0);
            end else if (pick < 65) begin
                send_frame(16'($urandom), 16'h0000, 0, 1'b1);
            end else if (pick < 75) begin
                do bad = 8'($urandom); while (bad == sync_b);
                send_byte(sync_a);
                send_byte(bad);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else begin
                send_frame(16'($urandom), 16'($urandom_range(1, 8)), $urandom_range(0, 10),
                           $urandom_range(0, 1) != 0);
            end
        end
    endtask

    initial begin
        logic [7:0] directed_q[$];
        logic [7:0] v;
        int len;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset framing: wrong second sync, good frame with extreme bytes,
        // zero-length header then one byte, and a check mismatch
        directed_q = '{8'h6D, 8'h00, 8'h62,
                       8'h6D, 8'h62, 8'hFF, 8'hFF, 8'h02, 8'h00, 8'h00, 8'hFF, 8'hCB, 8'hCA,
                       8'h6D, 8'h62, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5A,
                       8'h6D, 8'h62, 8'h34, 8'h12, 8'h01, 8'h00, 8'hA5, 8'hCA, 8'hCB};
        foreach (directed_q[i]) send_byte(directed_q[i]);
        run_random(RAND_PER_SETTING);
        drain();

        for (int s = 1; s < N_SETTINGS; s++) begin
            case (s)
                1: begin
                    write_cfg(CFG_SYNC_FIRST, 16'h0000);
                    write_cfg(CFG_SYNC_SECOND, 16'h00FF);
                    write_cfg(CFG_CHECK_VALUE, 16'h0000);
                end
                2: begin
                    write_cfg(CFG_SYNC_FIRST, 16'h00FF);
                    write_cfg(CFG_SYNC_SECOND, 16'h0000);
                    write_cfg(CFG_CHECK_VALUE, 16'hFFFF);
                end
                3: begin
                    // identical sync bytes
                    v = 8'($urandom);
                    write_cfg(CFG_SYNC_FIRST, {8'($urandom), v});
                    write_cfg(CFG_SYNC_SECOND, {8'h00, v});
                    write_cfg(CFG_CHECK_VALUE, 16'($urandom));
                    write_cfg(CFG_SPARE, 16'($urandom));
                end
                default: begin
                    write_cfg(CFG_SYNC_FIRST, 16'($urandom));
                    write_cfg(CFG_SYNC_SECOND, 16'($urandom));
                    write_cfg(CFG_CHECK_VALUE, 16'($urandom));
                end
            endcase
            if (s == 1) begin
                // buffer limit: exactly full ends normally, anything longer aborts
                len = $urandom_range(0, 1) ? MAX_PAYLOAD_DEF - 2 :
                      $urandom_range(MAX_PAYLOAD_DEF - 1, 65535);
                send_frame(16'($urandom), 16'(len), MAX_PAYLOAD_DEF - 2, 1'b1);
            end
            run_random(RAND_PER_SETTING);
            drain();
        end

        $display("Sent %0d bytes over %0d framing settings, including one buffer-limit frame.",
                 n_sent, N_SETTINGS);
        $display("Results seen: %0d payload, %0d good, %0d check mismatch, %0d aborted.",
                 n_data, n_good, n_bad, n_abort);
        if (fails == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/sfd_pkg.sv
rtl/sfd_cfg_regs.sv
rtl/sfd_parser.sv
rtl/serial_frame_deframer_unit.sv
dv/sfd_frame_checker.sv
dv/tb.sv
